/* design/owo_pkg.sv */
// Shared constants, types and tables of the omni wheel odometry unit.
package owo_pkg;

    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int MUL_AW  = 34;
    localparam int MUL_BW  = 27;
    localparam int PROD_W  = MUL_AW + MUL_BW;
    localparam int CRD_W   = 34;
    localparam int NUM_W   = 52;
    localparam int QUOT_W  = 31;

    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_COEF_X = 2'd1;
    localparam logic [1:0] REG_COEF_Y = 2'd2;
    localparam logic [1:0] REG_COEF_T = 2'd3;

    localparam logic [1:0] WHEEL_0    = 2'd0;
    localparam logic [1:0] WHEEL_1    = 2'd1;
    localparam logic [1:0] WHEEL_2    = 2'd2;
    localparam logic [1:0] WHEEL_NONE = 2'd3;

    localparam logic [19:0] WINDOW_RST = 20'd10000;
    localparam logic [23:0] COEF_X_RST = 24'd193728;
    localparam logic [23:0] COEF_Y_RST = 24'd111848;
    localparam logic [23:0] COEF_T_RST = 24'd1118481;

    localparam logic [3:0] MOP_VX  = 4'd0;
    localparam logic [3:0] MOP_VY  = 4'd1;
    localparam logic [3:0] MOP_WZ  = 4'd2;
    localparam logic [3:0] MOP_P   = 4'd3;
    localparam logic [3:0] MOP_PLO = 4'd4;
    localparam logic [3:0] MOP_PHI = 4'd5;
    localparam logic [3:0] MOP_CVX = 4'd6;
    localparam logic [3:0] MOP_SVY = 4'd7;
    localparam logic [3:0] MOP_SVX = 4'd8;
    localparam logic [3:0] MOP_CVY = 4'd9;
    localparam logic [3:0] MOP_RX  = 4'd10;
    localparam logic [3:0] MOP_RY  = 4'd11;

    localparam logic [24:0] TURN_MUL = 25'd22399067;
    localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [25:0] DT_MAX = 26'sd16777216;
    localparam logic signed [25:0] DT_MIN = -26'sd16777216;
    localparam logic [19:0] DIV_D = 20'd1000000;
    localparam logic [31:0] DIV_RECIP = 32'd2251799813;
    localparam logic signed [NUM_W-1:0] DIV_BIAS = 52'sd500000;

    typedef struct packed {
        logic       accept;
        logic       check;
        logic       dt_load;
        logic       first_sync;
        logic       mul_issue;
        logic       mul_wb;
        logic [3:0] mop;
        logic       cor_init;
        logic       cor_step;
        logic       cor_end;
        logic [4:0] step;
        logic       div_init;
        logic       div_step;
        logic       commit;
    } owo_cmd_t;

    typedef struct packed {
        logic wheel_ok;
        logic sync_ok;
        logic have_prev;
        logic out_free;
    } owo_stat_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] r;
        unique case (idx)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2F9;
            5'd15:   r = 32'h0000517C;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A2F;
            5'd19:   r = 32'h00000517;
            5'd20:   r = 32'h0000028B;
            5'd21:   r = 32'h00000145;
            5'd22:   r = 32'h000000A2;
            5'd23:   r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

/* design/owo_in_if.sv */
// Wheel measurement channel.
interface owo_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         wheel;
    logic signed [23:0] wheel_speed;
    logic [47:0]        stamp_us;

    modport source (output valid, output wheel, output wheel_speed, output stamp_us,
                    input ready);
    modport sink (input valid, input wheel, input wheel_speed, input stamp_us,
                  output ready);
endinterface

/* design/owo_out_if.sv */
// Odometry result channel.
interface owo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [23:0] turn_rate;
    logic [47:0]        odom_stamp_us;

    modport source (output valid, output pos_x, output pos_y, output heading,
                    output vel_x, output vel_y, output turn_rate, output odom_stamp_us,
                    input ready);
    modport sink (input valid, input pos_x, input pos_y, input heading,
                  input vel_x, input vel_y, input turn_rate, input odom_stamp_us,
                  output ready);
endinterface

/* design/omni_wheel_odometry_unit.sv */
// Top level of the three wheel omni drive odometry unit.
// Takes one wheel measurement per transfer and keeps the latest speed and stamp of each
// wheel; a measurement with the index WHEEL_NONE is ignored. When all three stamps lie
// pairwise closer than the sync window, the first such sync only records the earliest
// stamp; from the second on it forms the body twist, integrates the pose and hands out
// one result. The result is formed with the shared 34 x 27 multiplier, used for twelve
// products in turn, one CORDIC iteration per cycle and a reciprocal division for the
// metre scaling. A finished result waits in the output register while the next
// measurement is taken in; the following result holds in its commit state until that
// one is transferred.
module omni_wheel_odometry_unit
    import owo_pkg::*;
#(
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    owo_in_if.sink      meas,
    owo_out_if.source   odom
);

    owo_cmd_t  cmd;
    owo_stat_t stat;
    logic      in_ready;

    owo_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (meas.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    owo_datapath #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_wheel      (meas.wheel),
        .in_speed      (meas.wheel_speed),
        .in_stamp      (meas.stamp_us),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (odom.valid),
        .out_ready     (odom.ready),
        .out_pos_x     (odom.pos_x),
        .out_pos_y     (odom.pos_y),
        .out_heading   (odom.heading),
        .out_vel_x     (odom.vel_x),
        .out_vel_y     (odom.vel_y),
        .out_turn_rate (odom.turn_rate),
        .out_stamp     (odom.odom_stamp_us)
    );

    assign meas.ready = in_ready;

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (meas.valid && in_ready && meas.wheel != WHEEL_NONE) |=> !in_ready)
        else $error("measurement taken while previous one in progress");

    a_commit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!odom.valid || odom.ready))
        else $error("result overwrites an untaken result");

    a_one_unit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.mul_issue, cmd.mul_wb, cmd.cor_step, cmd.div_step, cmd.commit}))
        else $error("more than one datapath unit active");

    a_result_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> odom.valid)
        else $error("result missing after commit");

endmodule

/* design/owo_ctrl.sv */
// Sequencer of the odometry unit: steps the datapath through one measurement.
module owo_ctrl
    import owo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  owo_stat_t stat,
    output owo_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_DT     = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_WB     = 4'd4;
    localparam logic [3:0] S_CINIT  = 4'd5;
    localparam logic [3:0] S_CSTEP  = 4'd6;
    localparam logic [3:0] S_CEND   = 4'd7;
    localparam logic [3:0] S_DINIT  = 4'd8;
    localparam logic [3:0] S_DSTEP  = 4'd9;
    localparam logic [3:0] S_COMMIT = 4'd10;

    localparam logic [4:0] CRD_LAST = 5'(CORDIC_STEPS - 1);

    logic [3:0] state_reg, state_next;
    logic [3:0] mop_reg, mop_next;
    logic [4:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mop_reg   <= MOP_VX;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mop_reg   <= mop_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mop_next   = mop_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.mop    = mop_reg;
        cmd.step   = cnt_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.wheel_ok)
                        state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = stat.sync_ok ? S_DT : S_IDLE;
            end
            S_DT:
            begin
                if (stat.have_prev)
                begin
                    cmd.dt_load = 1'b1;
                    mop_next    = MOP_VX;
                    state_next  = S_MUL;
                end
                else
                begin
                    cmd.first_sync = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_MUL:
            begin
                cmd.mul_issue = 1'b1;
                state_next    = S_WB;
            end
            S_WB:
            begin
                cmd.mul_wb = 1'b1;
                if (mop_reg == MOP_PHI)
                    state_next = S_CINIT;
                else if (mop_reg == MOP_RY)
                    state_next = S_DINIT;
                else
                begin
                    mop_next   = mop_reg + 4'd1;
                    state_next = S_MUL;
                end
            end
            S_CINIT:
            begin
                cmd.cor_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_CSTEP;
            end
            S_CSTEP:
            begin
                cmd.cor_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == CRD_LAST)
                    state_next = S_CEND;
            end
            S_CEND:
            begin
                cmd.cor_end = 1'b1;
                mop_next    = MOP_CVX;
                state_next  = S_MUL;
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.div_step = 1'b1;
                state_next   = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* design/owo_datapath.sv */
// Datapath of the odometry unit: stores, shared multiplier, CORDIC, divider, pose.
module owo_datapath
    import owo_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic [1:0]         in_wheel,
    input  logic signed [23:0] in_speed,
    input  logic [47:0]        in_stamp,
    input  owo_cmd_t           cmd,
    output owo_stat_t          stat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_pos_x,
    output logic signed [31:0] out_pos_y,
    output logic [15:0]        out_heading,
    output logic signed [23:0] out_vel_x,
    output logic signed [23:0] out_vel_y,
    output logic signed [23:0] out_turn_rate,
    output logic [47:0]        out_stamp
);

    localparam int HS_R = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
    localparam int HS_L = (ANGLE_BITS >= 16) ? 0 : 16 - ANGLE_BITS;

    function automatic logic signed [23:0] rnd_sat24(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] t;
        logic signed [23:0]       r;
        t = (v + (PROD_W'(1) <<< 23)) >>> 24;
        if (t > PROD_W'(8388607))
            r = 24'sh7FFFFF;
        else if (t < -PROD_W'(8388608))
            r = -24'sh800000;
        else
            r = t[23:0];
        return r;
    endfunction

    function automatic logic signed [25:0] rnd30(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] t;
        t = (v + (PROD_W'(1) <<< 29)) >>> 30;
        return t[25:0];
    endfunction

    logic [19:0] win_reg;
    logic [23:0] cx_reg, cy_reg, ct_reg;
    logic signed [23:0] speed_reg [3];
    logic [47:0] stamp_reg [3];
    logic signed [31:0] posx_reg, posy_reg;
    logic [ANGLE_BITS-1:0] heading_reg, full_reg;
    logic [47:0] prev_reg, tmin_reg;
    logic have_prev_reg;

    logic signed [25:0] dt_reg;
    logic signed [23:0] vx_reg, vy_reg, wz_reg;
    logic signed [49:0] p_reg;
    logic [63:0] pm_reg;
    logic signed [PROD_W-1:0] prod_reg, acc_reg;
    logic signed [25:0] rx_reg, ry_reg;
    logic signed [NUM_W-1:0] nx_reg, ny_reg;
    logic signed [CRD_W-1:0] x_reg, y_reg, z_reg, cs_reg, sn_reg;
    logic flip_reg;
    logic [47:0] mx_reg, my_reg;
    logic [QUOT_W-1:0] qx_reg, qy_reg;
    logic negx_reg, negy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= WINDOW_RST;
            cx_reg  <= COEF_X_RST;
            cy_reg  <= COEF_Y_RST;
            ct_reg  <= COEF_T_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW: win_reg <= cfg_data[19:0];
                REG_COEF_X: cx_reg  <= cfg_data;
                REG_COEF_Y: cy_reg  <= cfg_data;
                REG_COEF_T: ct_reg  <= cfg_data;
                default:    win_reg <= win_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                speed_reg[k] <= '0;
                stamp_reg[k] <= '0;
            end
        end
        else if (cmd.accept)
        begin
            unique case (in_wheel)
                WHEEL_0:
                begin
                    speed_reg[0] <= in_speed;
                    stamp_reg[0] <= in_stamp;
                end
                WHEEL_1:
                begin
                    speed_reg[1] <= in_speed;
                    stamp_reg[1] <= in_stamp;
                end
                WHEEL_2:
                begin
                    speed_reg[2] <= in_speed;
                    stamp_reg[2] <= in_stamp;
                end
                WHEEL_NONE:
                begin
                    speed_reg[0] <= speed_reg[0];
                end
                default:
                begin
                    speed_reg[0] <= speed_reg[0];
                end
            endcase
        end
    end

    logic [47:0] s0, s1, s2, d01, d12, d20, tmin;
    logic [47:0] win_ext;

    always_comb
    begin
        s0 = stamp_reg[0];
        s1 = stamp_reg[1];
        s2 = stamp_reg[2];
        d01 = (s0 > s1) ? s0 - s1 : s1 - s0;
        d12 = (s1 > s2) ? s1 - s2 : s2 - s1;
        d20 = (s2 > s0) ? s2 - s0 : s0 - s2;
        win_ext = {28'd0, win_reg};
        if (s0 < s1 && s0 < s2)
            tmin = s0;
        else if (s1 < s2 && s1 < s0)
            tmin = s1;
        else
            tmin = s2;
    end

    assign stat.wheel_ok  = (in_wheel != WHEEL_NONE);
    assign stat.sync_ok   = (d01 < win_ext) && (d12 < win_ext) && (d20 < win_ext);
    assign stat.have_prev = have_prev_reg;
    assign stat.out_free  = !out_valid || out_ready;

    logic signed [48:0] dt_raw;
    logic signed [25:0] dt_sat;

    always_comb
    begin
        dt_raw = signed'({1'b0, tmin_reg}) - signed'({1'b0, prev_reg});
        if (dt_raw > 49'(DT_MAX))
            dt_sat = DT_MAX;
        else if (dt_raw < 49'(DT_MIN))
            dt_sat = DT_MIN;
        else
            dt_sat = dt_raw[25:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            prev_reg      <= '0;
        end
        else if (cmd.dt_load || cmd.first_sync)
        begin
            have_prev_reg <= 1'b1;
            prev_reg      <= tmin_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check)
            tmin_reg <= tmin;
        if (cmd.dt_load)
            dt_reg <= dt_sat;
    end

    // shared multiplier
    logic signed [24:0] wd_x;
    logic signed [26:0] wd_y;
    logic signed [25:0] wd_s;
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;

    always_comb
    begin
        wd_x = 25'(speed_reg[0]) - 25'(speed_reg[2]);
        wd_y = (27'(speed_reg[1]) <<< 1) - 27'(speed_reg[0]) - 27'(speed_reg[2]);
        wd_s = 26'(speed_reg[0]) + 26'(speed_reg[1]) + 26'(speed_reg[2]);
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mop)
            MOP_VX:
            begin
                mul_a = signed'({10'd0, cx_reg});
                mul_b = MUL_BW'(wd_x);
            end
            MOP_VY:
            begin
                mul_a = signed'({10'd0, cy_reg});
                mul_b = wd_y;
            end
            MOP_WZ:
            begin
                mul_a = signed'({10'd0, ct_reg});
                mul_b = MUL_BW'(wd_s);
            end
            MOP_P:
            begin
                mul_a = MUL_AW'(dt_reg);
                mul_b = MUL_BW'(wz_reg);
            end
            MOP_PLO:
            begin
                mul_a = signed'({9'd0, p_reg[24:0]});
                mul_b = signed'({2'd0, TURN_MUL});
            end
            MOP_PHI:
            begin
                mul_a = MUL_AW'(signed'(p_reg[49:25]));
                mul_b = signed'({2'd0, TURN_MUL});
            end
            MOP_CVX:
            begin
                mul_a = cs_reg;
                mul_b = MUL_BW'(vx_reg);
            end
            MOP_SVY:
            begin
                mul_a = sn_reg;
                mul_b = MUL_BW'(vy_reg);
            end
            MOP_SVX:
            begin
                mul_a = sn_reg;
                mul_b = MUL_BW'(vx_reg);
            end
            MOP_CVY:
            begin
                mul_a = cs_reg;
                mul_b = MUL_BW'(vy_reg);
            end
            MOP_RX:
            begin
                mul_a = MUL_AW'(rx_reg);
                mul_b = MUL_BW'(dt_reg);
            end
            MOP_RY:
            begin
                mul_a = MUL_AW'(ry_reg);
                mul_b = MUL_BW'(dt_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_issue)
            prod_reg <= mul_a * mul_b;
        if (cmd.mul_wb)
        begin
            unique case (cmd.mop)
                MOP_VX:  vx_reg <= rnd_sat24(prod_reg);
                MOP_VY:  vy_reg <= rnd_sat24(prod_reg);
                MOP_WZ:  wz_reg <= rnd_sat24(-prod_reg);
                MOP_P:   p_reg  <= prod_reg[49:0];
                MOP_PLO: pm_reg <= 64'(prod_reg);
                MOP_PHI: pm_reg <= pm_reg + (64'(prod_reg) << 25);
                MOP_CVX: acc_reg <= prod_reg;
                MOP_SVY: rx_reg <= rnd30(acc_reg - prod_reg);
                MOP_SVX: acc_reg <= prod_reg;
                MOP_CVY: ry_reg <= rnd30(acc_reg + prod_reg);
                MOP_RX:  nx_reg <= NUM_W'(prod_reg) + DIV_BIAS;
                MOP_RY:  ny_reg <= NUM_W'(prod_reg) + DIV_BIAS;
                default: acc_reg <= acc_reg;
            endcase
        end
    end

    // yaw change and CORDIC
    logic [63:0] fsum, hsum;
    logic [ANGLE_BITS-1:0] full_c, half_c, mid_c;
    logic [31:0] ang, ang_f;
    logic fold;
    logic signed [CRD_W-1:0] xs, ys, atan_c;

    always_comb
    begin
        fsum   = pm_reg + (64'd1 << (62 - ANGLE_BITS));
        hsum   = pm_reg + (64'd1 << (63 - ANGLE_BITS));
        full_c = fsum[63-ANGLE_BITS +: ANGLE_BITS];
        half_c = hsum[64-ANGLE_BITS +: ANGLE_BITS];
        mid_c  = heading_reg + half_c;
        ang    = 32'(mid_c) << (32 - ANGLE_BITS);
        fold   = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
        ang_f  = fold ? {~ang[31], ang[30:0]} : ang;
        xs     = x_reg >>> cmd.step;
        ys     = y_reg >>> cmd.step;
        atan_c = signed'({2'd0, atan_entry(cmd.step)});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cor_init)
        begin
            full_reg <= full_c;
            flip_reg <= fold;
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= CRD_W'(signed'(ang_f));
        end
        else if (cmd.cor_step)
        begin
            if (!z_reg[CRD_W-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_c;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_c;
            end
        end
        if (cmd.cor_end)
        begin
            cs_reg <= flip_reg ? -x_reg : x_reg;
            sn_reg <= flip_reg ? -y_reg : y_reg;
        end
    end

    // floor division by one million on two lanes: reciprocal estimate, then correct by one
    logic [NUM_W-1:0] mx, my;
    logic [63:0] ex, ey;
    logic [47:0] tx, ty;
    logic gex, gey;

    always_comb
    begin
        mx  = nx_reg[NUM_W-1] ? ~nx_reg : nx_reg;
        my  = ny_reg[NUM_W-1] ? ~ny_reg : ny_reg;
        ex  = 64'(mx[47:16]) * 64'(DIV_RECIP);
        ey  = 64'(my[47:16]) * 64'(DIV_RECIP);
        tx  = mx_reg - 48'(qx_reg) * 48'(DIV_D);
        ty  = my_reg - 48'(qy_reg) * 48'(DIV_D);
        gex = (tx >= 48'(DIV_D));
        gey = (ty >= 48'(DIV_D));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            mx_reg   <= mx[47:0];
            my_reg   <= my[47:0];
            qx_reg   <= {2'd0, ex[63:35]};
            qy_reg   <= {2'd0, ey[63:35]};
            negx_reg <= nx_reg[NUM_W-1];
            negy_reg <= ny_reg[NUM_W-1];
        end
        else if (cmd.div_step)
        begin
            qx_reg <= qx_reg + QUOT_W'(gex);
            qy_reg <= qy_reg + QUOT_W'(gey);
        end
    end

    // pose update and output register
    logic signed [31:0] dx, dy, posx_next, posy_next;
    logic [ANGLE_BITS-1:0] heading_next;
    logic [15:0] hout;

    always_comb
    begin
        dx = negx_reg ? ~{1'b0, qx_reg} : {1'b0, qx_reg};
        dy = negy_reg ? ~{1'b0, qy_reg} : {1'b0, qy_reg};
        posx_next    = posx_reg + dx;
        posy_next    = posy_reg + dy;
        heading_next = heading_reg + full_reg;
        hout         = 16'((40'(heading_next) >> HS_R) << HS_L);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            posx_reg    <= '0;
            posy_reg    <= '0;
            heading_reg <= '0;
            out_valid   <= 1'b0;
        end
        else if (cmd.commit)
        begin
            posx_reg    <= posx_next;
            posy_reg    <= posy_next;
            heading_reg <= heading_next;
            out_valid   <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_pos_x     <= posx_next;
            out_pos_y     <= posy_next;
            out_heading   <= hout;
            out_vel_x     <= vx_reg;
            out_vel_y     <= vy_reg;
            out_turn_rate <= wz_reg;
            out_stamp     <= tmin_reg;
        end
    end

endmodule
